@@ rtl/core/assert_macros.svh @@
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ rtl/core/pfte_pkg.sv @@
package pfte_pkg;

  localparam int unsigned TR_DEPTH  = 64;
  localparam int unsigned ACT_DEPTH = 32;

  localparam int unsigned TR_AW  = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
  localparam int unsigned ACT_AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int unsigned TR_CW  = $clog2(TR_DEPTH + 1);
  localparam int unsigned ACT_CW = $clog2(ACT_DEPTH + 1);
  localparam int unsigned IDX_W  = (TR_CW > ACT_CW) ? TR_CW : ACT_CW;

  // Transition entry: {from, event, next}; action entry: {state, action}.
  localparam int unsigned TR_DW  = 24;
  localparam int unsigned ACT_DW = 16;

  typedef enum logic [1:0] {
    REQ_ADD_TR  = 2'd0,
    REQ_ADD_ACT = 2'd1,
    REQ_EVENT   = 2'd2,
    REQ_RESTART = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_MISS      = 2'd1,
    STAT_NO_ACTION = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_TSCAN,
    FSM_ASCAN,
    FSM_FINISH
  } fsm_e;

endpackage

@@ rtl/core/pfte_req_if.sv @@
interface pfte_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] state_code;
  logic [7:0] event_code;
  logic [7:0] next_state_code;
  logic [7:0] action_code;

  modport source (
    output valid, req_type, state_code, event_code, next_state_code, action_code,
    input  ready
  );
  modport sink (
    input  valid, req_type, state_code, event_code, next_state_code, action_code,
    output ready
  );
endinterface

@@ rtl/core/pfte_rsp_if.sv @@
interface pfte_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] new_state;
  logic [7:0] fired_action;
  logic       action_valid;

  modport source (
    output valid, status, new_state, fired_action, action_valid,
    input  ready
  );
  modport sink (
    input  valid, status, new_state, fired_action, action_valid,
    output ready
  );
endinterface

@@ rtl/core/pfte_cfg_if.sv @@
interface pfte_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

@@ rtl/core/pfte_ram.sv @@
module pfte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/programmable_fsm_transition_engine_top.sv @@
// Per word: an add or a missed event walks one table, comparing its entries in turn; an event
// that hits walks both tables, first the transition table and then the action table.
// Throughput: one word at a time; a single compare unit walks one table entry per cycle.
// A restart skips the table walk. A finished result waits in the output register.
// Reset: fill counts cleared, current state and initial_state go to 0; no clearing pass.
`include "assert_macros.svh"

module programmable_fsm_transition_engine_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  pfte_req_if.sink   req_i,
  pfte_rsp_if.source rsp_o,
  pfte_cfg_if.sink   cfg_i
);

  pfte_pkg::fsm_e state_q, state_d;

  logic [7:0] init_q;
  logic [7:0] cur_q, cur_d;

  logic [pfte_pkg::TR_CW-1:0]  tr_cnt_q, tr_cnt_d;
  logic [pfte_pkg::ACT_CW-1:0] act_cnt_q, act_cnt_d;

  logic [pfte_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [pfte_pkg::IDX_W-1:0] cidx_q, cidx_d;
  logic                       pend_q, pend_d;
  logic [15:0]                key_q, key_d;

  pfte_pkg::req_e req_q, req_d;
  logic [7:0] st_q, st_d, ev_q, ev_d, nx_q, nx_d, ac_q, ac_d;

  pfte_pkg::status_e res_status_q, res_status_d;
  logic [7:0]        res_fired_q, res_fired_d;
  logic              res_fv_q, res_fv_d;

  logic       rsp_valid_q, rsp_valid_d;
  logic [1:0] rsp_status_q, rsp_status_d;
  logic [7:0] rsp_state_q, rsp_state_d;
  logic [7:0] rsp_fired_q, rsp_fired_d;
  logic       rsp_fv_q, rsp_fv_d;

  logic                       tr_we;
  logic [pfte_pkg::TR_AW-1:0] tr_waddr;
  logic [pfte_pkg::TR_DW-1:0] tr_wdata, tr_rdata;

  logic                        act_we;
  logic [pfte_pkg::ACT_AW-1:0] act_waddr;
  logic [pfte_pkg::ACT_DW-1:0] act_wdata, act_rdata;

  logic [15:0]                cmp_lhs;
  logic                       cmp_hit;
  logic [pfte_pkg::IDX_W-1:0] cnt_lim;
  logic                       more;
  logic                       req_acc;

  pfte_ram #(
    .WIDTH (pfte_pkg::TR_DW),
    .DEPTH (pfte_pkg::TR_DEPTH)
  ) u_tr_ram (
    .clk_i   (clk_i),
    .we_i    (tr_we),
    .waddr_i (tr_waddr),
    .wdata_i (tr_wdata),
    .raddr_i (idx_q[pfte_pkg::TR_AW-1:0]),
    .rdata_o (tr_rdata)
  );

  pfte_ram #(
    .WIDTH (pfte_pkg::ACT_DW),
    .DEPTH (pfte_pkg::ACT_DEPTH)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_we),
    .waddr_i (act_waddr),
    .wdata_i (act_wdata),
    .raddr_i (idx_q[pfte_pkg::ACT_AW-1:0]),
    .rdata_o (act_rdata)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == pfte_pkg::FSM_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.new_state    = rsp_state_q;
  assign rsp_o.fired_action = rsp_fired_q;
  assign rsp_o.action_valid = rsp_fv_q;

  // Shared key compare; the read data belongs to entry cidx_q when pend_q is set.
  assign cmp_lhs = (state_q == pfte_pkg::FSM_ASCAN) ? {8'h00, act_rdata[15:8]}
                                                    : tr_rdata[23:8];
  assign cmp_hit = pend_q && (cmp_lhs == key_q);
  assign cnt_lim = (state_q == pfte_pkg::FSM_ASCAN) ? pfte_pkg::IDX_W'(act_cnt_q)
                                                    : pfte_pkg::IDX_W'(tr_cnt_q);
  assign more    = idx_q < cnt_lim;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    tr_cnt_d     = tr_cnt_q;
    act_cnt_d    = act_cnt_q;
    idx_d        = idx_q;
    cidx_d       = cidx_q;
    pend_d       = pend_q;
    key_d        = key_q;
    req_d        = req_q;
    st_d         = st_q;
    ev_d         = ev_q;
    nx_d         = nx_q;
    ac_d         = ac_q;
    res_status_d = res_status_q;
    res_fired_d  = res_fired_q;
    res_fv_d     = res_fv_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_state_d  = rsp_state_q;
    rsp_fired_d  = rsp_fired_q;
    rsp_fv_d     = rsp_fv_q;
    tr_we        = 1'b0;
    tr_waddr     = cidx_q[pfte_pkg::TR_AW-1:0];
    tr_wdata     = {st_q, ev_q, nx_q};
    act_we       = 1'b0;
    act_waddr    = cidx_q[pfte_pkg::ACT_AW-1:0];
    act_wdata    = {st_q, ac_q};

    unique case (state_q)
      pfte_pkg::FSM_IDLE: begin
        if (req_acc) begin
          req_d        = pfte_pkg::req_e'(req_i.req_type);
          st_d         = req_i.state_code;
          ev_d         = req_i.event_code;
          nx_d         = req_i.next_state_code;
          ac_d         = req_i.action_code;
          idx_d        = '0;
          pend_d       = 1'b0;
          res_status_d = pfte_pkg::STAT_OK;
          res_fired_d  = 8'h00;
          res_fv_d     = 1'b0;
          unique case (pfte_pkg::req_e'(req_i.req_type))
            pfte_pkg::REQ_ADD_TR: begin
              key_d   = {req_i.state_code, req_i.event_code};
              state_d = pfte_pkg::FSM_TSCAN;
            end
            pfte_pkg::REQ_ADD_ACT: begin
              key_d   = {8'h00, req_i.state_code};
              state_d = pfte_pkg::FSM_ASCAN;
            end
            pfte_pkg::REQ_EVENT: begin
              key_d   = {cur_q, req_i.event_code};
              state_d = pfte_pkg::FSM_TSCAN;
            end
            pfte_pkg::REQ_RESTART: begin
              cur_d   = init_q;
              state_d = pfte_pkg::FSM_FINISH;
            end
            default: state_d = pfte_pkg::FSM_IDLE;
          endcase
        end
      end

      pfte_pkg::FSM_TSCAN: begin
        if (cmp_hit) begin
          if (req_q == pfte_pkg::REQ_ADD_TR) begin
            tr_we   = 1'b1;
            state_d = pfte_pkg::FSM_FINISH;
          end else begin
            // Event hit: move now, then look for the entered state's action.
            cur_d   = tr_rdata[7:0];
            key_d   = {8'h00, tr_rdata[7:0]};
            idx_d   = '0;
            pend_d  = 1'b0;
            state_d = pfte_pkg::FSM_ASCAN;
          end
        end else if (more) begin
          cidx_d = idx_q;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          if (req_q == pfte_pkg::REQ_ADD_TR) begin
            if (tr_cnt_q < pfte_pkg::TR_CW'(pfte_pkg::TR_DEPTH)) begin
              tr_we    = 1'b1;
              tr_waddr = tr_cnt_q[pfte_pkg::TR_AW-1:0];
              tr_cnt_d = tr_cnt_q + 1'b1;
            end else begin
              res_status_d = pfte_pkg::STAT_FULL;
            end
          end else begin
            res_status_d = pfte_pkg::STAT_MISS;
          end
          state_d = pfte_pkg::FSM_FINISH;
        end
      end

      pfte_pkg::FSM_ASCAN: begin
        if (cmp_hit) begin
          if (req_q == pfte_pkg::REQ_ADD_ACT) begin
            act_we = 1'b1;
          end else begin
            res_fired_d = act_rdata[7:0];
            res_fv_d    = 1'b1;
          end
          state_d = pfte_pkg::FSM_FINISH;
        end else if (more) begin
          cidx_d = idx_q;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          if (req_q == pfte_pkg::REQ_ADD_ACT) begin
            if (act_cnt_q < pfte_pkg::ACT_CW'(pfte_pkg::ACT_DEPTH)) begin
              act_we    = 1'b1;
              act_waddr = act_cnt_q[pfte_pkg::ACT_AW-1:0];
              act_cnt_d = act_cnt_q + 1'b1;
            end else begin
              res_status_d = pfte_pkg::STAT_FULL;
            end
          end else begin
            res_status_d = pfte_pkg::STAT_NO_ACTION;
          end
          state_d = pfte_pkg::FSM_FINISH;
        end
      end

      pfte_pkg::FSM_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_state_d  = cur_q;
          rsp_fired_d  = res_fired_q;
          rsp_fv_d     = res_fv_q;
          state_d      = pfte_pkg::FSM_IDLE;
        end
      end

      default: state_d = pfte_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfte_pkg::FSM_IDLE;
      init_q      <= 8'h00;
      cur_q       <= 8'h00;
      tr_cnt_q    <= '0;
      act_cnt_q   <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      tr_cnt_q    <= tr_cnt_d;
      act_cnt_q   <= act_cnt_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        init_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q       <= cidx_d;
    key_q        <= key_d;
    req_q        <= req_d;
    st_q         <= st_d;
    ev_q         <= ev_d;
    nx_q         <= nx_d;
    ac_q         <= ac_d;
    res_status_q <= res_status_d;
    res_fired_q  <= res_fired_d;
    res_fv_q     <= res_fv_d;
    rsp_status_q <= rsp_status_d;
    rsp_state_q  <= rsp_state_d;
    rsp_fired_q  <= rsp_fired_d;
    rsp_fv_q     <= rsp_fv_d;
  end

  `ASSERT_IMP(a_tr_bound, 1'b1, tr_cnt_q <= pfte_pkg::TR_CW'(pfte_pkg::TR_DEPTH), "tr overflow")
  `ASSERT_NXT(a_tr_up, 1'b1, tr_cnt_q >= $past(tr_cnt_q), "tr count fell")
  `ASSERT_NXT(a_act_up, 1'b1, act_cnt_q >= $past(act_cnt_q), "action count fell")
  `ASSERT_NXT(a_rsp_hold, rsp_valid_q && !rsp_o.ready, rsp_valid_q, "word dropped")
  `ASSERT_IMP(a_fv_status, rsp_valid_q && rsp_fv_q, rsp_status_q == pfte_pkg::STAT_OK, "bad flag")

endmodule

@@ tb/tb_programmable_fsm_transition_engine_top.sv @@
`timescale 1ns / 1ps

class fsm_scoreboard;

  typedef struct packed {
    pfte_pkg::status_e status;
    logic [7:0]        new_state;
    logic [7:0]        fired_action;
    logic              action_valid;
  } response_t;

  typedef struct packed {
    logic [7:0] from_state;
    logic [7:0] event_code;
    logic [7:0] target;
  } transition_t;

  typedef struct packed {
    logic [7:0] state_code;
    logic [7:0] action_code;
  } binding_t;

  logic [7:0]  start_state;
  logic [7:0]  cur_state;
  transition_t transitions[pfte_pkg::TR_DEPTH];
  binding_t    bindings[pfte_pkg::ACT_DEPTH];
  int          tr_fill;
  int          act_fill;
  response_t   expected_responses[$];
  int          errors;
  int          checked;

  function new();
    start_state = 8'h00;
    cur_state   = 8'h00;
    tr_fill     = 0;
    act_fill    = 0;
    errors      = 0;
    checked     = 0;
  endfunction

  function void set_initial_state(logic [7:0] value);
    start_state = value;
  endfunction

  // Slots fill in order and are never freed, so only the first fill-count entries matter.
  function int find_transition(logic [7:0] from_state, logic [7:0] ev);
    for (int i = 0; i < tr_fill; i++) begin
      if (transitions[i].from_state == from_state && transitions[i].event_code == ev) begin
        return i;
      end
    end
    return -1;
  endfunction

  function int find_binding(logic [7:0] state);
    for (int i = 0; i < act_fill; i++) begin
      if (bindings[i].state_code == state) begin
        return i;
      end
    end
    return -1;
  endfunction

  function void apply_request(pfte_pkg::req_e kind, logic [7:0] st, logic [7:0] ev,
                              logic [7:0] nx, logic [7:0] ac);
    response_t r;
    int        slot;
    r.status       = pfte_pkg::STAT_OK;
    r.fired_action = 8'h00;
    r.action_valid = 1'b0;
    case (kind)
      pfte_pkg::REQ_ADD_TR: begin
        slot = find_transition(st, ev);
        if (slot >= 0) begin
          transitions[slot].target = nx;
        end else if (tr_fill < pfte_pkg::TR_DEPTH) begin
          transitions[tr_fill] = '{from_state: st, event_code: ev, target: nx};
          tr_fill++;
        end else begin
          r.status = pfte_pkg::STAT_FULL;
        end
      end
      pfte_pkg::REQ_ADD_ACT: begin
        slot = find_binding(st);
        if (slot >= 0) begin
          bindings[slot].action_code = ac;
        end else if (act_fill < pfte_pkg::ACT_DEPTH) begin
          bindings[act_fill] = '{state_code: st, action_code: ac};
          act_fill++;
        end else begin
          r.status = pfte_pkg::STAT_FULL;
        end
      end
      pfte_pkg::REQ_RESTART: cur_state = start_state;
      default: begin
        slot = find_transition(cur_state, ev);
        if (slot < 0) begin
          r.status = pfte_pkg::STAT_MISS;
        end else begin
          cur_state = transitions[slot].target;
          slot = find_binding(cur_state);
          if (slot < 0) begin
            r.status = pfte_pkg::STAT_NO_ACTION;
          end else begin
            r.fired_action = bindings[slot].action_code;
            r.action_valid = 1'b1;
          end
        end
      end
    endcase
    r.new_state = cur_state;
    expected_responses.push_back(r);
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH: %s", what);
    errors++;
  endtask

  task check_response(logic [1:0] st, logic [7:0] ns, logic [7:0] fa, logic av);
    response_t want;
    if (expected_responses.size() == 0) begin
      report_mismatch($sformatf("unexpected word status=%0d state=%02h action=%02h/%0b",
                                st, ns, fa, av));
      return;
    end
    want = expected_responses.pop_front();
    if (st !== want.status || ns !== want.new_state ||
        fa !== want.fired_action || av !== want.action_valid) begin
      report_mismatch($sformatf(
          "word %0d: got status=%0d state=%02h action=%02h/%0b, want %0d %02h %02h/%0b",
          checked, st, ns, fa, av, want.status, want.new_state, want.fired_action,
          want.action_valid));
    end
    checked++;
  endtask

endclass

module tb_programmable_fsm_transition_engine_top;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfte_req_if req_if ();
  pfte_rsp_if rsp_if ();
  pfte_cfg_if cfg_if ();

  programmable_fsm_transition_engine_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  fsm_scoreboard sb;
  int unsigned   req_gap;
  bit            req_burst;
  bit            rsp_burst;
  int unsigned   rsp_hold;

  function automatic int unsigned idle_cycles(bit burst);
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // valid stays high across back-to-back words; it is dropped when a gap follows or when draining
  task automatic send_request(input pfte_pkg::req_e kind, input logic [7:0] st,
                              input logic [7:0] ev, input logic [7:0] nx,
                              input logic [7:0] ac);
    repeat (req_gap) @(posedge clk_i);
    req_if.valid           <= 1'b1;
    req_if.req_type        <= kind;
    req_if.state_code      <= st;
    req_if.event_code      <= ev;
    req_if.next_state_code <= nx;
    req_if.action_code     <= ac;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.apply_request(kind, st, ev, nx, ac);
    req_gap = idle_cycles(req_burst);
    if (req_gap > 0) begin
      req_if.valid <= 1'b0;
    end
  endtask

  task automatic drain_responses(input int unsigned extra);
    if (req_gap == 0) begin
      req_if.valid <= 1'b0;
      req_gap = 1;
    end
    while (sb.expected_responses.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_initial_state(input logic [7:0] value);
    drain_responses(8);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_initial_state(value);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Narrow mode keeps keys in a small pool so events mostly hit; wide mode mixes
  // pool keys with keys spread over the full range and fills both tables.
  task automatic random_request(input bit wide);
    pfte_pkg::req_e kind;
    logic [7:0]     st, ev, nx, ac;
    int unsigned    pick;
    bit             wide_key;
    pick = $urandom_range(0, 99);
    if (wide) begin
      kind = pick < 40 ? pfte_pkg::REQ_ADD_TR : pick < 70 ? pfte_pkg::REQ_ADD_ACT
           : pick < 95 ? pfte_pkg::REQ_EVENT : pfte_pkg::REQ_RESTART;
    end else begin
      kind = pick < 25 ? pfte_pkg::REQ_ADD_TR : pick < 40 ? pfte_pkg::REQ_ADD_ACT
           : pick < 90 ? pfte_pkg::REQ_EVENT : pfte_pkg::REQ_RESTART;
    end
    wide_key = wide && ($urandom_range(0, 1) == 1);
    st = wide_key ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7));
    ev = wide_key ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
    nx = (wide_key || $urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
       : 8'($urandom_range(0, 7));
    ac = 8'($urandom_range(0, 255));
    send_request(kind, st, ev, nx, ac);
  endtask

  task automatic random_phase(input int count, input bit wide);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        req_burst = ($urandom_range(0, 3) == 0);
      end
      random_request(wide);
    end
  endtask

  initial begin : watchdog
    #2_000_000;
    $display("programmable_fsm_transition_engine_top test failed");
    $finish;
  end

  initial begin : rsp_sink
    int unsigned gap;
    int unsigned taken;
    rsp_if.ready = 1'b0;
    taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    rsp_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_response(rsp_if.status, rsp_if.new_state, rsp_if.fired_action,
                          rsp_if.action_valid);
        taken++;
        if (taken % 64 == 0) begin
          rsp_burst = ($urandom_range(0, 3) == 0);
        end
        if (rsp_hold > 0) begin
          gap = rsp_hold;
          rsp_hold = 0;
        end else begin
          gap = idle_cycles(rsp_burst);
        end
        if (gap > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    sb        = new();
    req_gap   = 0;
    req_burst = 1'b0;
    rsp_burst = 1'b0;
    rsp_hold  = 0;
    rst_ni    = 1'b0;
    req_if.valid           = 1'b0;
    req_if.req_type        = pfte_pkg::REQ_ADD_TR;
    req_if.state_code      = 8'h00;
    req_if.event_code      = 8'h00;
    req_if.next_state_code = 8'h00;
    req_if.action_code     = 8'h00;
    cfg_if.valid = 1'b0;
    cfg_if.data  = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: misses, hits with and without an action, overwrites, restarts
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_ADD_TR,  8'h00, 8'h00, 8'hFF, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_ADD_ACT, 8'hFF, 8'h00, 8'h00, 8'hA5);
    send_request(pfte_pkg::REQ_ADD_TR,  8'hFF, 8'hFF, 8'h00, 8'hFF);
    send_request(pfte_pkg::REQ_EVENT,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_request(pfte_pkg::REQ_ADD_ACT, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_ADD_ACT, 8'hFF, 8'h00, 8'h00, 8'h5A);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'hFF, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_ADD_TR,  8'hFF, 8'hFF, 8'h80, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'h12, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'hFF, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_RESTART, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // new initial state must not move the current state until a restart
    write_initial_state(8'hFF);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'hFF, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_RESTART, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'hFF, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_ADD_ACT, 8'h80, 8'h00, 8'h00, 8'hFF);
    send_request(pfte_pkg::REQ_RESTART, 8'h00, 8'h00, 8'h00, 8'h00);
    send_request(pfte_pkg::REQ_EVENT,   8'h00, 8'hFF, 8'h00, 8'h00);

    write_initial_state(8'($urandom_range(0, 7)));
    random_phase(500, 1'b0);

    // wide keys: both tables fill, later new keys report full
    write_initial_state(8'hFF);
    random_phase(500, 1'b1);

    write_initial_state(8'h00);
    // long receiver stall while words keep coming, so the input backs up
    rsp_hold = 400;
    random_phase(200, 1'b0);
    drain_responses(0);
    random_phase(200, 1'b0);

    drain_responses(120);
    if (sb.errors == 0) begin
      $display("programmable_fsm_transition_engine_top test passed");
    end else begin
      $display("programmable_fsm_transition_engine_top test failed");
    end
    $finish;
  end

endmodule
